@@ rtl/aggregate_tag_deframer_assert.svh @@
// assertion macros for the aggregate tag deframer
`ifndef AGGREGATE_TAG_DEFRAMER_ASSERT_SVH
`define AGGREGATE_TAG_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off while arst_n is low
`define ATD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");
// next-cycle implication, clocked on clk, off while arst_n is low
`define ATD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");
`else
`define ATD_ASSERT_NOW(lbl, ante, cons)
`define ATD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/atd_pkg.sv @@
// shared types and constants of the aggregate tag deframer
package atd_pkg;

	localparam int LENGTH_BITS_DEF = 24;

	localparam logic [7:0] KIND_AUDIO    = 8'h08;
	localparam logic [7:0] KIND_VIDEO    = 8'h09;
	localparam int         HDR_BYTES     = 11;
	localparam int         TRAILER_BYTES = 4;

	typedef enum logic [1:0] {
		STATUS_AUDIO   = 2'd0,
		STATUS_VIDEO   = 2'd1,
		STATUS_OVERRUN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_DONE   = 3'b001,
		PH_HEADER = 3'b010,
		PH_SKIP   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [31:0] message_timestamp;
		logic [23:0] message_length;
		logic        first_of_message;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [23:0] body_length;
		logic [23:0] body_offset;
		logic [31:0] frame_timestamp;
		status_t     tag_status;
	} result_t;

endpackage

@@ rtl/aggregate_tag_deframer.sv @@
// aggregate tag deframer: splits an aggregate media message into tag descriptors
//
// slave channel: one payload byte per transaction; tuser marks the first byte of
// a message, which also carries the message length and the message timestamp
// master channel: one descriptor per audio or video tag that fits in the message,
// or one overrun descriptor when a tag body runs past the message end
// other tag kinds, headers cut off by the message end and all body and trailer
// bytes give no descriptor
// descriptor path: the transaction carrying the last header byte of a tag loads
// the input register; the descriptor is then loaded into the result register,
// which raises m_axis_tvalid
// throughput: one byte per cycle sustained while m_axis_tready does not stall a
// descriptor; the parse state updates as a byte moves on to the result register
// stall: while a descriptor waits on m_axis_tready the input register still takes
// one byte; further bytes wait until the descriptor is taken
// reset: arst_n clears all parse state; the block then ignores bytes until a byte
// with the first-of-message flag arrives
module aggregate_tag_deframer #(
	parameter int LENGTH_BITS = atd_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// data_byte[7:0], message_length[31:8], message_timestamp[63:32]
	input  logic [63:0] s_axis_tdata,
	// first_of_message[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frame_timestamp[31:0], body_offset[55:32], body_length[79:56]
	output logic [79:0] m_axis_tdata,
	// tag_status[1:0]
	output logic [1:0]  m_axis_tuser
);
	import atd_pkg::*;

	// input register stage
	logic    item_valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    res_valid;
	result_t res;
	result_t res_q;

	// the held byte moves on when the result register is free or being emptied
	assign advance       = item_valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			item_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_byte         <= s_axis_tdata[7:0];
			item_s1.message_length    <= s_axis_tdata[31:8];
			item_s1.message_timestamp <= s_axis_tdata[63:32];
			item_s1.first_of_message  <= s_axis_tuser;
		end
	end

	// parse state and descriptor generation
	atd_parse #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	atd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.taken  (m_axis_tready),
		.valid_q(m_axis_tvalid),
		.res_q  (res_q)
	);

	assign m_axis_tdata = {res_q.body_length, res_q.body_offset, res_q.frame_timestamp};
	assign m_axis_tuser = res_q.tag_status;

`include "aggregate_tag_deframer_assert.svh"

	// a byte that cannot move on stays in the input register
	`ATD_ASSERT_NEXT(a_s1_holds, item_valid_s1 && !advance, item_valid_s1)
	// a descriptor produced by the parser is always offered next cycle
	`ATD_ASSERT_NEXT(a_res_offered, advance && res_valid, m_axis_tvalid)
	// a stalled descriptor stays offered and unchanged
	`ATD_ASSERT_NEXT(a_m_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

@@ rtl/atd_parse.sv @@
// tag parser: message state, header assembly and descriptor generation
module atd_parse #(
	parameter int LENGTH_BITS = atd_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  atd_pkg::item_t  item,
	output logic            res_valid,
	output atd_pkg::result_t res
);
	import atd_pkg::*;

	localparam int SumW = ((LENGTH_BITS > 24) ? LENGTH_BITS : 24) + 1;
	localparam logic [3:0] HdrLast = 4'(HDR_BYTES - 1);

	phase_t                 phase_q;
	logic [LENGTH_BITS-1:0] pos_q;
	logic [3:0]             hidx_q;
	logic [7:0]             kind_q;
	logic [23:0]            size_q;
	logic [31:0]            ttime_q;
	logic [31:0]            base_q;
	logic                   base_valid_q;
	logic [24:0]            skip_q;
	logic [LENGTH_BITS-1:0] hlen_q;
	logic [31:0]            hts_q;

	phase_t                 phase_d;
	logic [LENGTH_BITS-1:0] pos_d;
	logic [3:0]             hidx_d;
	logic [7:0]             kind_d;
	logic [23:0]            size_d;
	logic [31:0]            ttime_d;
	logic [31:0]            base_d;
	logic                   base_valid_d;
	logic [24:0]            skip_d;
	logic [LENGTH_BITS-1:0] hlen_d;
	logic [31:0]            hts_d;
	logic                   res_valid_d;
	result_t                res_d;
	logic [LENGTH_BITS-1:0] body;
	logic [SumW-1:0]        body_end;
	logic [31:0]            base_eff;

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		hidx_d       = hidx_q;
		kind_d       = kind_q;
		size_d       = size_q;
		ttime_d      = ttime_q;
		base_d       = base_q;
		base_valid_d = base_valid_q;
		skip_d       = skip_q;
		hlen_d       = hlen_q;
		hts_d        = hts_q;
		res_valid_d  = 1'b0;
		res_d        = '0;
		body         = pos_q + 1'b1;
		body_end     = '0;
		base_eff     = base_q;

		if (item_valid) begin
			// new message: restart and latch length and timestamp
			if (item.first_of_message) begin
				phase_d      = PH_HEADER;
				pos_d        = '0;
				hidx_d       = '0;
				base_valid_d = 1'b0;
				skip_d       = '0;
				hlen_d       = LENGTH_BITS'(item.message_length);
				hts_d        = item.message_timestamp;
			end

			body = pos_d + 1'b1;
			if (phase_d != PH_DONE) begin
				if (pos_d >= hlen_d) begin
					phase_d = PH_DONE;
				end else begin
					pos_d = body;
					if (phase_d == PH_SKIP) begin
						if (skip_d != '0)
							skip_d = skip_d - 1'b1;
						if (skip_d == '0) begin
							phase_d = PH_HEADER;
							hidx_d  = '0;
						end
					end else begin
						case (hidx_d)
							4'd0: kind_d = item.data_byte;
							4'd1: size_d[23:16] = item.data_byte;
							4'd2: size_d[15:8] = item.data_byte;
							4'd3: size_d[7:0] = item.data_byte;
							4'd4: ttime_d = {8'h00, item.data_byte, 16'h0000};
							4'd5: ttime_d[15:8] = item.data_byte;
							4'd6: ttime_d[7:0] = item.data_byte;
							4'd7: ttime_d[31:24] = item.data_byte;
							default: ;
						endcase

						if (hidx_d == HdrLast) begin
							hidx_d   = '0;
							body_end = SumW'(body) + SumW'(size_d);
							res_d.body_offset = 24'(body);
							res_d.body_length = size_d;
							if (body_end > SumW'(hlen_d)) begin
								// body runs past the message end
								res_valid_d      = 1'b1;
								res_d.tag_status = STATUS_OVERRUN;
								phase_d          = PH_DONE;
							end else begin
								base_eff = base_valid_d ? base_d : ttime_d;
								base_d       = base_eff;
								base_valid_d = 1'b1;
								res_d.frame_timestamp = hts_d + (ttime_d - base_eff);
								if (kind_d == KIND_AUDIO) begin
									res_valid_d      = 1'b1;
									res_d.tag_status = STATUS_AUDIO;
								end else if (kind_d == KIND_VIDEO) begin
									res_valid_d      = 1'b1;
									res_d.tag_status = STATUS_VIDEO;
								end
								skip_d  = 25'(size_d) + 25'(TRAILER_BYTES);
								phase_d = PH_SKIP;
							end
						end else begin
							hidx_d = hidx_d + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DONE;
			pos_q        <= '0;
			hidx_q       <= '0;
			kind_q       <= '0;
			size_q       <= '0;
			ttime_q      <= '0;
			base_q       <= '0;
			base_valid_q <= 1'b0;
			skip_q       <= '0;
			hlen_q       <= '0;
			hts_q        <= '0;
		end else begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			hidx_q       <= hidx_d;
			kind_q       <= kind_d;
			size_q       <= size_d;
			ttime_q      <= ttime_d;
			base_q       <= base_d;
			base_valid_q <= base_valid_d;
			skip_q       <= skip_d;
			hlen_q       <= hlen_d;
			hts_q        <= hts_d;
		end
	end

	assign res_valid = res_valid_d;
	assign res       = res_d;

`include "aggregate_tag_deframer_assert.svh"

	`ATD_ASSERT_NOW(a_skip_hidx_clear, phase_q == PH_SKIP, hidx_q == '0)
	`ATD_ASSERT_NEXT(a_overrun_ends, res_valid && res.tag_status == STATUS_OVERRUN, phase_q == PH_DONE)
	`ATD_ASSERT_NEXT(a_tag_then_skip, res_valid && res.tag_status != STATUS_OVERRUN, phase_q == PH_SKIP && base_valid_q)

endmodule

@@ rtl/atd_out_reg.sv @@
// result register holding one descriptor until the receiver takes it
module atd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  atd_pkg::result_t res,
	input  logic             taken,
	output logic             valid_q,
	output atd_pkg::result_t res_q
);
	import atd_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
